[src/pwm_timer_setting_calculator_unit_defines.svh]
// ----------------------------------------------------------------------------
// PWM timer setting calculator: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PWM_TIMER_SETTING_CALCULATOR_UNIT_DEFINES_SVH
`define PWM_TIMER_SETTING_CALCULATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define PWTSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pwtsc assertion failed");

// next-cycle implication
`define PWTSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pwtsc assertion failed");

`endif

[src/pwtsc_pkg.sv]
// ----------------------------------------------------------------------------
// PWM timer setting calculator: package
// Widths, reset values, codes and transaction types shared by all modules.
// ----------------------------------------------------------------------------
package pwtsc_pkg;

  localparam int unsigned FW         = 27;
  localparam int unsigned DW         = 11;
  localparam int unsigned TW         = 16;
  localparam int unsigned AW         = 26;
  localparam int unsigned SW         = 39;
  localparam int unsigned DIV_STAGES = 27;
  localparam int unsigned DUTY_SHIFT = 10;
  localparam int unsigned SLOW_SHIFT = 3;

  localparam logic [FW-1:0] CLOCK_RST = 27'd16000000;
  localparam logic [FW-1:0] THR_RST   = 27'd245;
  localparam logic [FW-1:0] TOP_MAX   = 27'd65535;

  localparam logic [1:0] MODE_PWM  = 2'd0;
  localparam logic [1:0] MODE_LOW  = 2'd1;
  localparam logic [1:0] MODE_HIGH = 2'd2;

  localparam logic [1:0] REG_CLOCK = 2'd0;
  localparam logic [1:0] REG_THR   = 2'd1;

  typedef struct packed {
    logic [FW-1:0] tick;
    logic [FW-1:0] freq;
    logic [DW-1:0] duty;
    logic          slow;
  } req_t;

  typedef struct packed {
    logic [TW-1:0] top;
    logic [TW-1:0] cmp;
    logic [1:0]    mode;
    logic          slow;
  } res_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

[src/pwtsc_front.sv]
// ----------------------------------------------------------------------------
// PWM timer setting calculator: front end
// Holds configuration, accepts requests, picks the prescaler and tick rate.
// ----------------------------------------------------------------------------
module pwtsc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [26:0]           freq_hz_in,
  input  logic [10:0]           duty,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [26:0]           cfg_data,
  output pwtsc_pkg::hs_t        push_hs,
  input  logic                  q_ready,
  output pwtsc_pkg::req_t       q_data
);
  import pwtsc_pkg::*;

  logic [FW-1:0] clock_hz;
  logic [FW-1:0] thr_hz;
  logic          fv;
  req_t          req;
  logic          slow;

  assign cfg_ready = 1'b1;
  assign in_ready  = !fv || q_ready;
  assign slow      = freq_hz_in < thr_hz;
  assign push_hs.valid = fv;
  assign push_hs.ready = q_ready;
  assign q_data    = req;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= CLOCK_RST;
      thr_hz   <= THR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CLOCK: clock_hz <= cfg_data;
        REG_THR:   thr_hz   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (in_ready) begin
      fv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req.tick <= slow ? (clock_hz >> SLOW_SHIFT) : clock_hz;
      req.freq <= freq_hz_in;
      req.duty <= duty;
      req.slow <= slow;
    end
  end

endmodule

[src/pwtsc_queue.sv]
// ----------------------------------------------------------------------------
// PWM timer setting calculator: request queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module pwtsc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            ready,
  input  pwtsc_pkg::req_t wdata,
  output logic            valid,
  input  logic            pop,
  output pwtsc_pkg::req_t rdata
);
  import pwtsc_pkg::*;

  req_t       mem [0:1];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       do_push;
  logic       do_pop;

  assign ready   = cnt != 2'd2;
  assign valid   = cnt != 2'd0;
  assign do_push = push && ready;
  assign do_pop  = pop && valid;
  assign rdata   = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= !wp;
      if (do_pop)  rp <= !rp;
      case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= wdata;
  end

endmodule

[src/pwtsc_div.sv]
// ----------------------------------------------------------------------------
// PWM timer setting calculator: pipelined divider
// Restoring divider, one quotient bit per stage; divide by zero gives all ones.
// ----------------------------------------------------------------------------
module pwtsc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [26:0] dividend,
  input  logic [26:0] divisor,
  input  logic [38:0] side_in,
  output logic        out_valid,
  output logic [26:0] quotient,
  output logic [38:0] side_out
);
  import pwtsc_pkg::*;

  logic          v   [1:DIV_STAGES];
  logic [FW-1:0] rem [1:DIV_STAGES];
  logic [FW-1:0] quo [1:DIV_STAGES];
  logic [FW-1:0] dvd [1:DIV_STAGES];
  logic [FW-1:0] dvs [1:DIV_STAGES];
  logic [SW-1:0] sd  [1:DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic          p_v;
    logic [FW-1:0] p_rem;
    logic [FW-1:0] p_quo;
    logic [FW-1:0] p_dvd;
    logic [FW-1:0] p_dvs;
    logic [SW-1:0] p_sd;
    logic [FW:0]   rem_sh;
    logic [FW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign p_v   = in_valid;
      assign p_rem = '0;
      assign p_quo = '0;
      assign p_dvd = dividend;
      assign p_dvs = divisor;
      assign p_sd  = side_in;
    end else begin : g_rest
      assign p_v   = v[k];
      assign p_rem = rem[k];
      assign p_quo = quo[k];
      assign p_dvd = dvd[k];
      assign p_dvs = dvs[k];
      assign p_sd  = sd[k];
    end

    assign rem_sh = {p_rem, p_dvd[FW-1]};
    assign diff   = rem_sh - {1'b0, p_dvs};
    assign ge     = rem_sh >= {1'b0, p_dvs};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? diff[FW-1:0] : rem_sh[FW-1:0];
        quo[k+1] <= {p_quo[FW-2:0], ge};
        dvd[k+1] <= {p_dvd[FW-2:0], 1'b0};
        dvs[k+1] <= p_dvs;
        sd[k+1]  <= p_sd;
      end
    end
  end

  assign out_valid = v[DIV_STAGES];
  assign quotient  = quo[DIV_STAGES];
  assign side_out  = sd[DIV_STAGES];

endmodule

[src/pwtsc_back.sv]
// ----------------------------------------------------------------------------
// PWM timer setting calculator: back end
// Period divide, compare and mode, frequency divide and the output register.
// ----------------------------------------------------------------------------
module pwtsc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_pop,
  input  pwtsc_pkg::req_t q_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [15:0]     top_count,
  output logic [15:0]     compare_count,
  output logic [1:0]      output_mode,
  output logic            prescale_select,
  output logic [25:0]     actual_freq_hz
);
  import pwtsc_pkg::*;

  logic          en;
  logic          d1_v;
  logic [FW-1:0] d1_q;
  logic [SW-1:0] d1_sd;
  logic [FW-1:0] d1_tick;
  logic [DW-1:0] d1_duty;
  logic          d1_slow;

  logic [FW-1:0] top_raw;
  logic [FW-1:0] top_clp;
  logic [TW-1:0] top_c;
  logic [TW:0]   tp1;
  logic [TW+DW:0] prod;
  logic [TW+1:0] counts;
  res_t          res_c;

  logic          p_v;
  logic [FW-1:0] p_tick;
  res_t          p_res;

  logic          d2_v;
  logic [FW-1:0] d2_q;
  logic [SW-1:0] d2_sd;
  res_t          d2_res;

  assign en    = !out_valid || out_ready;
  assign q_pop = en && q_valid;

  pwtsc_div u_div_top (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (q_valid),
    .dividend (q_data.tick),
    .divisor  (q_data.freq),
    .side_in  ({q_data.tick, q_data.duty, q_data.slow}),
    .out_valid(d1_v),
    .quotient (d1_q),
    .side_out (d1_sd)
  );

  assign {d1_tick, d1_duty, d1_slow} = d1_sd;

  always_comb begin
    top_raw = (d1_q == '0) ? '0 : d1_q - 27'd1;
    top_clp = (top_raw > TOP_MAX) ? TOP_MAX : top_raw;
    top_c   = (top_clp == '0) ? 16'd1 : top_clp[TW-1:0];
    tp1     = {1'b0, top_c} + 17'd1;
    prod    = {11'b0, tp1} * {17'b0, d1_duty};
    counts  = prod[TW+DW:DUTY_SHIFT];
    res_c.top  = top_c;
    res_c.slow = d1_slow;
    res_c.cmp  = '0;
    if (counts == '0) begin
      res_c.mode = MODE_LOW;
    end else if (counts >= {1'b0, tp1}) begin
      res_c.mode = MODE_HIGH;
    end else begin
      res_c.mode = MODE_PWM;
      res_c.cmp  = counts[TW-1:0] - 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (en) begin
      p_v <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_tick <= d1_tick;
      p_res  <= res_c;
    end
  end

  pwtsc_div u_div_freq (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (p_v),
    .dividend (p_tick),
    .divisor  ({11'b0, p_res.top} + 27'd1),
    .side_in  ({4'b0, p_res}),
    .out_valid(d2_v),
    .quotient (d2_q),
    .side_out (d2_sd)
  );

  assign d2_res = d2_sd[$bits(res_t)-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      top_count       <= d2_res.top;
      compare_count   <= d2_res.cmp;
      output_mode     <= d2_res.mode;
      prescale_select <= d2_res.slow;
      actual_freq_hz  <= d2_q[AW-1:0];
    end
  end

endmodule

[src/pwm_timer_setting_calculator_unit.sv]
// ----------------------------------------------------------------------------
// PWM timer setting calculator: top level
// Turns a PWM frequency and duty into timer top, compare, mode and prescaler.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    freq_hz_in, duty
//   out      output     out_valid / out_ready  top_count, compare_count,
//                                              output_mode, prescale_select,
//                                              actual_freq_hz
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One transaction per cycle sustained while out_ready holds; path is front
// register, queue, two 27-stage divider pipelines, compare stage and output.
// Synchronous reset clears control state and loads the default registers.
// An output stall freezes the back end; the queue and front keep accepting
// until the queue fills. Configuration writes are always taken.
// ----------------------------------------------------------------------------
`include "pwm_timer_setting_calculator_unit_defines.svh"

module pwm_timer_setting_calculator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [26:0] freq_hz_in,
  input  logic [10:0] duty,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] top_count,
  output logic [15:0] compare_count,
  output logic [1:0]  output_mode,
  output logic        prescale_select,
  output logic [25:0] actual_freq_hz,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [26:0] cfg_data
);
  import pwtsc_pkg::*;

  hs_t  push_hs;
  logic q_ready;
  req_t f_data;
  logic q_valid;
  logic q_pop;
  req_t q_data;

  pwtsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .freq_hz_in(freq_hz_in),
    .duty      (duty),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push_hs   (push_hs),
    .q_ready   (q_ready),
    .q_data    (f_data)
  );

  pwtsc_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push_hs.valid),
    .ready(q_ready),
    .wdata(f_data),
    .valid(q_valid),
    .pop  (q_pop),
    .rdata(q_data)
  );

  pwtsc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_data         (q_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .top_count      (top_count),
    .compare_count  (compare_count),
    .output_mode    (output_mode),
    .prescale_select(prescale_select),
    .actual_freq_hz (actual_freq_hz)
  );

  `PWTSC_ASSERT_NOW(a_pwm_cmp_below_top, out_valid && output_mode == MODE_PWM, compare_count < top_count)
  `PWTSC_ASSERT_NOW(a_forced_cmp_zero, out_valid && output_mode != MODE_PWM, compare_count == 16'd0)
  `PWTSC_ASSERT_NOW(a_top_nonzero, out_valid, top_count != 16'd0)
  `PWTSC_ASSERT_NEXT(a_front_held, push_hs.valid && !push_hs.ready, push_hs.valid)

endmodule

[test/pwm_timer_setting_calculator_unit_checker.sv]
// ----------------------------------------------------------------------------
// PWM timer setting calculator: checker
// Tracks the register writes and predicts top, compare, mode, prescaler and
// frequency for each accepted request. Compares results in order.
// ----------------------------------------------------------------------------
module pwm_timer_setting_calculator_unit_checker
  import pwtsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [26:0] freq_hz_in,
  input  logic [10:0] duty,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] top_count,
  input  logic [15:0] compare_count,
  input  logic [1:0]  output_mode,
  input  logic        prescale_select,
  input  logic [25:0] actual_freq_hz,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [26:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  typedef struct {
    logic [15:0] top;
    logic [15:0] cmp;
    logic [1:0]  mode;
    logic        slow;
    logic [25:0] freq;
  } setting_t;

  logic [26:0] clock_reg;
  logic [26:0] thr_reg;
  setting_t    settings_q[$];

  function automatic setting_t calc_setting(logic [26:0] freq, logic [10:0] dv);
    setting_t    s;
    logic [26:0] tick;
    longint      top;
    longint      counts;
    s.slow = freq < thr_reg;
    tick = s.slow ? (clock_reg >> 3) : clock_reg;
    if (freq == 0) begin
      top = 65535;
    end else begin
      top = longint'(tick) / longint'(freq);
      if (top > 0) top = top - 1;
      if (top > 65535) top = 65535;
    end
    if (top < 1) top = 1;
    counts = ((top + 1) * longint'(dv)) / 1024;
    s.cmp = '0;
    if (counts == 0) begin
      s.mode = MODE_LOW;
    end else if (counts >= top + 1) begin
      s.mode = MODE_HIGH;
    end else begin
      s.mode = MODE_PWM;
      s.cmp = 16'(counts - 1);
    end
    s.top = 16'(top);
    s.freq = 26'(longint'(tick) / (top + 1));
    return s;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d, want %0d (result %0d)", what, got, want, checked);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    checked = 0;
  end

  assign pending = settings_q.size();

  always @(posedge clk) begin
    setting_t w;
    if (rst) begin
      clock_reg <= CLOCK_RST;
      thr_reg <= THR_RST;
      settings_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (settings_q.size() == 0) begin
          report_mismatch("unexpected result", top_count, 0);
        end else begin
          w = settings_q.pop_front();
          if (top_count != w.top) report_mismatch("top_count", top_count, w.top);
          if (compare_count != w.cmp) report_mismatch("compare_count", compare_count, w.cmp);
          if (output_mode != w.mode) report_mismatch("output_mode", output_mode, w.mode);
          if (prescale_select != w.slow)
            report_mismatch("prescale_select", prescale_select, w.slow);
          if (actual_freq_hz != w.freq)
            report_mismatch("actual_freq_hz", actual_freq_hz, w.freq);
        end
        checked++;
      end
      if (in_valid && in_ready) settings_q.push_back(calc_setting(freq_hz_in, duty));
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CLOCK) clock_reg <= cfg_data;
        else if (cfg_index == REG_THR) thr_reg <= cfg_data;
      end
    end
  end

endmodule

[test/pwm_timer_setting_calculator_unit_tb.sv]
// ----------------------------------------------------------------------------
// PWM timer setting calculator: testbench top
// Drives directed and random requests across several clock and threshold
// settings with random stalls on both sides; the checker scores results.
// ----------------------------------------------------------------------------
module pwm_timer_setting_calculator_unit_tb;
  import pwtsc_pkg::*;

  localparam logic [1:0] REG_NONE  = 2'd2;
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [26:0] freq_hz_in;
  logic [10:0] duty;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] top_count;
  logic [15:0] compare_count;
  logic [1:0]  output_mode;
  logic        prescale_select;
  logic [25:0] actual_freq_hz;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [26:0] cfg_data;
  int          fail_count;
  int          pending;
  int          checked;
  int          cycles;
  int          stall_left;
  int          sent;
  bit          quiet;

  pwm_timer_setting_calculator_unit u_top (.*);

  pwm_timer_setting_calculator_unit_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("pwm_timer_setting_calculator_unit regression: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_request(logic [26:0] f, logic [10:0] d);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    freq_hz_in <= f;
    duty <= d;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [26:0] val);
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [26:0] rand_freq();
    int w;
    w = $urandom_range(0, 27);
    return 27'($urandom & ((32'd1 << w) - 1));
  endfunction

  function automatic logic [10:0] rand_duty();
    if ($urandom_range(0, 5) == 0) return 11'($urandom);
    return 11'($urandom_range(0, 1024));
  endfunction

  initial begin
    logic [26:0] clk_set[6] = '{27'd1000000, 27'd100000000, 27'd0, 27'h7FFFFFF,
                                27'd16000000, 27'd12345678};
    logic [26:0] thr_set[6] = '{27'd1, 27'd100000000, 27'd0, 27'h7FFFFFF,
                                27'd245, 27'd50000};
    cycles = 0;
    sent = 0;
    quiet = 0;
    rst = 1;
    in_valid = 0;
    freq_hz_in = '0;
    duty = '0;
    cfg_valid = 0;
    cfg_index = REG_CLOCK;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send_request(27'd1000, 11'd512);
    send_request(27'd1, 11'd0);
    send_request(27'd1, 11'd1024);
    send_request(27'd0, 11'd300);
    send_request(27'd0, 11'd2047);
    send_request(27'd244, 11'd1);
    send_request(27'd245, 11'd1);
    send_request(27'h7FFFFFF, 11'd1023);
    send_request(27'd100000000, 11'd512);
    send_request(27'd8000000, 11'd512);
    send_request(27'd16000000, 11'd700);
    send_request(27'd4000000, 11'd1);
    send_request(27'd20000, 11'd1025);
    send_request(27'd20000, 11'd1023);
    send_request(27'd2, 11'd2);
    send_request(27'd30, 11'd1000);
    write_reg(REG_CLOCK, 27'd0);
    send_request(27'd1000, 11'd512);
    send_request(27'd0, 11'd512);
    write_reg(REG_SPARE, 27'h7FFFFFF);
    write_reg(REG_NONE, 27'd5);
    send_request(27'd50, 11'd100);

    for (int p = 0; p < 6; p++) begin
      write_reg(REG_CLOCK, clk_set[p]);
      write_reg(REG_THR, thr_set[p]);
      if (p == 5) quiet = 1;
      repeat (80) begin
        if ($urandom_range(0, 3) == 0) send_request(27'($urandom), rand_duty());
        else send_request(rand_freq(), rand_duty());
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (64) @(posedge clk);
    $display("sent %0d requests over 7 register settings, %0d results checked",
             sent, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("pwm_timer_setting_calculator_unit regression: pass");
    end else begin
      $display("pwm_timer_setting_calculator_unit regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/pwtsc_pkg.sv
src/pwtsc_front.sv
src/pwtsc_queue.sv
src/pwtsc_div.sv
src/pwtsc_back.sv
src/pwm_timer_setting_calculator_unit.sv
test/pwm_timer_setting_calculator_unit_checker.sv
test/pwm_timer_setting_calculator_unit_tb.sv
